// ----- rtl/svas_pkg.sv -----
// ----------------------------------------------------------------------------
// svas_pkg
// shared constants, pitch table and controller/datapath command types
// ----------------------------------------------------------------------------
package svas_pkg;

   localparam int SINE_ENTRIES  = 8192;
   localparam int PITCH_ENTRIES = 256;
   localparam int SINE_AW       = $clog2(SINE_ENTRIES);
   localparam int SINE_NW       = $clog2(SINE_ENTRIES + 1);

   localparam logic [63:0] PITCH_TOP = 64'd67878804062;
   localparam logic [63:0] SEMI_DOWN = 64'd126684666;
   localparam logic [63:0] ROT_BASE  = 64'd3294199;
   localparam logic [25:0] ROT_K     =
      26'((ROT_BASE * 64'd8192 + 64'(SINE_ENTRIES / 2)) / 64'(SINE_ENTRIES));

   localparam int CSR_AW = 2;
   localparam logic [CSR_AW-1:0] REG_SET0_ENV  = 2'd0;
   localparam logic [CSR_AW-1:0] REG_SET0_TONE = 2'd1;
   localparam logic [CSR_AW-1:0] REG_SET1_ENV  = 2'd2;
   localparam logic [CSR_AW-1:0] REG_SET1_TONE = 2'd3;

   typedef logic [36:0] pitch_word_type;
   typedef pitch_word_type pitch_rom_type [PITCH_ENTRIES];

   // semitone table, built from the top entry down, each lower index a semitone down
   function automatic pitch_rom_type build_pitch_rom();
      logic [63:0]   f;
      pitch_rom_type r;
      f = PITCH_TOP;
      for (int i = 0; i < PITCH_ENTRIES; i++) begin
         r[PITCH_ENTRIES-1-i] = f[36:0];
         f = (f * SEMI_DOWN) >> 27;
      end
      return r;
   endfunction

   localparam pitch_rom_type PITCH_ROM = build_pitch_rom();

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_TRIG,
      OP_ATK,
      OP_DEC,
      OP_OSC,
      OP_SRD,
      OP_WAVE,
      OP_PIT_LO,
      OP_PIT_HI,
      OP_PIT_FIN,
      OP_AMP_A,
      OP_AMP_B,
      OP_AMP_FIN,
      OP_LOW_LO,
      OP_LOW_HI,
      OP_LOW_FIN,
      OP_RES_LO,
      OP_RES_HI,
      OP_RES_FIN,
      OP_BND_LO,
      OP_BND_HI,
      OP_BND_FIN,
      OP_FX_LO,
      OP_FX_HI,
      OP_FX_FIN,
      OP_FY_LO,
      OP_FY_HI,
      OP_FY_FIN
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      capture;
      logic      load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic fill_last;
   } dp_status_type;

endpackage

// ----- rtl/synth_voice_adsr_svf_core.sv -----
// ----------------------------------------------------------------------------
// synth_voice_adsr_svf_core
// one synthesizer voice: adsr envelope, five waveforms, pitch drop, svf
// ----------------------------------------------------------------------------
// After reset the core builds its sine table with a rotation recurrence, one
// pass of the FX and FY steps per entry, and keeps req_tready low until that
// is done; csr writes are taken at any time. For each transaction the
// sequencer walks the single 26x26 multiplier through the pitch drop, the
// gain and the three filter products, each wide one split in two halves.
// The result sits in an output register, so the next transaction can be
// accepted while it waits. Write the csr registers only while the core is idle.
module synth_voice_adsr_svf_core import svas_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] note_code
   input  logic              req_tuser,   // [0] row_start
   // response channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // [31:0] voice_sample
   // register write port
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [63:0]       csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: fill pass, then one walk of the datapath per transaction
   svas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // voice state, sine memory and the shared multiplier
   svas_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_row_start (req_tuser),
      .in_note_code (req_tdata),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .out_sample   (rsp_tdata)
   );

endmodule

// ----- rtl/svas_dp.sv -----
// ----------------------------------------------------------------------------
// svas_dp
// voice datapath: registers, sine memory, shared 26x26 multiplier
// ----------------------------------------------------------------------------
module svas_dp import svas_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_status_type     status,
   input  logic              in_row_start,
   input  logic [7:0]        in_note_code,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [63:0]       csr_wdata,
   output logic [31:0]       out_sample
);

   localparam logic [1:0] STG_ATTACK  = 2'd0;
   localparam logic [1:0] STG_DECAY   = 2'd1;
   localparam logic [1:0] STG_SUSTAIN = 2'd2;
   localparam logic [1:0] STG_RELEASE = 2'd3;

   localparam logic [7:0] WAVE_SQUARE = 8'd1;
   localparam logic [7:0] WAVE_SAW    = 8'd2;
   localparam logic [7:0] WAVE_TRI    = 8'd3;
   localparam logic [7:0] WAVE_NOISE  = 8'd4;

   localparam logic [7:0] FLT_HIGH  = 8'd1;
   localparam logic [7:0] FLT_BAND  = 8'd2;
   localparam logic [7:0] FLT_NOTCH = 8'd3;

   function automatic logic [21:0] rate_of(input logic [7:0] b);
      logic [7:0] idx;
      idx = b + 8'd64;
      return PITCH_ROM[idx][36:15];
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
      logic signed [47:0] r;
      if (v[50:47] == {4{v[47]}}) r = v[47:0];
      else if (v[50])             r = {1'b1, 47'b0};
      else                        r = {1'b0, {47{1'b1}}};
      return r;
   endfunction

   // configuration
   logic [31:0] set0_env_ff, set1_env_ff;
   logic [63:0] set0_tone_ff, set1_tone_ff;

   // captured transaction
   logic       row_ff;
   logic [7:0] code_ff;

   // voice state
   logic [31:0]        phase_ff, phase_in;
   logic signed [23:0] level_ff, level_in;
   logic [1:0]         stage_ff, stage_in;
   logic signed [37:0] pitch_ff, pitch_in;
   logic signed [47:0] low_ff, low_in;
   logic signed [47:0] band_ff, band_in;
   logic signed [47:0] high_ff, high_in;
   logic               set_ff, set_in;
   logic [63:0]        noise_ff, noise_in;

   // working registers
   logic signed [17:0] res_ff, res_in;
   logic signed [21:0] x_ff, x_in;
   logic signed [48:0] diff_ff, diff_in;
   logic [15:0]        f2_ff, f2_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [35:0] cx_ff, cx_in;
   logic signed [35:0] cy_ff, cy_in;
   logic [SINE_AW-1:0] fill_idx_ff, fill_idx_in;
   logic [31:0]        out_ff;

   // sine memory
   logic signed [17:0] sine_mem [SINE_ENTRIES];
   logic signed [17:0] sine_q_ff;
   logic [SINE_AW-1:0] sine_addr;
   logic               mem_we;
   logic [31+SINE_NW:0] sine_scaled;

   logic [31:0] env_w;
   logic [63:0] tone_w, tone_trig;
   logic [36:0] drop_w, drop_trig, note_w;
   logic [7:0]  drop_idx, drop_trig_idx, note_idx;
   logic [16:0] drop_fac;

   logic signed [25:0] mul_a, mul_b;
   logic signed [51:0] prod;
   logic signed [63:0] prod_ext;
   logic [4:0]         mul_sh;
   logic               mul_hi;

   logic signed [63:0] acc_sh14, acc_sh7, acc_sh16, acc_sh28, acc_sh32;
   logic signed [24:0] lvl_ext, lvl_add, lvl_sub_d, lvl_sub_r;
   logic signed [32:0] tri_d;
   logic [32:0]        tri_abs;
   logic signed [18:0] tri_val;
   logic [63:0]        n1, n2, n3;
   logic signed [48:0] y_w;
   logic [31:0]        y_sat;

   assign env_w  = set_ff ? set1_env_ff : set0_env_ff;
   assign tone_w = set_ff ? set1_tone_ff : set0_tone_ff;
   assign drop_idx = tone_w[63:56] + 8'd64;
   assign drop_w   = PITCH_ROM[drop_idx];
   assign drop_fac = 17'h10000 - {9'b0, tone_w[55:48]};

   // trigger path uses the set named by the new note code
   assign tone_trig     = code_ff[7] ? set1_tone_ff : set0_tone_ff;
   assign drop_trig_idx = tone_trig[63:56] + 8'd64;
   assign drop_trig     = PITCH_ROM[drop_trig_idx];
   assign note_idx      = tone_trig[15:8] + {1'b0, code_ff[6:0]};
   assign note_w        = PITCH_ROM[note_idx];

   assign acc_sh14 = acc_ff >>> 14;
   assign acc_sh7  = acc_ff >>> 7;
   assign acc_sh16 = acc_ff >>> 16;
   assign acc_sh28 = acc_ff >>> 28;
   assign acc_sh32 = acc_ff >>> 32;

   assign lvl_ext   = {level_ff[23], level_ff};
   assign lvl_add   = lvl_ext + $signed({3'b0, rate_of(env_w[7:0])});
   assign lvl_sub_d = lvl_ext - $signed({3'b0, rate_of(env_w[15:8])});
   assign lvl_sub_r = lvl_ext - $signed({3'b0, rate_of(env_w[31:24])});

   // triangle: |2(phase - half)| >> 15 == |phase - half| >> 14
   assign tri_d   = $signed({1'b0, phase_ff}) - 33'sh80000000;
   assign tri_abs = tri_d[32] ? 33'(-tri_d) : 33'(tri_d);
   assign tri_val = $signed({1'b0, tri_abs[31:14]}) - 19'sh10000;

   // xorshift noise
   assign n1 = noise_ff ^ (noise_ff << 13);
   assign n2 = n1 ^ (n1 >> 7);
   assign n3 = n2 ^ (n2 << 17);

   assign sine_scaled = {{SINE_NW{1'b0}}, phase_ff} * (32+SINE_NW)'(SINE_ENTRIES);
   assign sine_addr   = (cmd.op == OP_FX_LO) ? fill_idx_ff : sine_scaled[32 +: SINE_AW];
   assign mem_we      = (cmd.op == OP_FX_LO);

   // shared multiplier operand select
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_sh = '0;
      mul_hi = 1'b0;
      case (cmd.op)
         OP_PIT_LO: begin
            mul_a = $signed({7'b0, pitch_ff[18:0]});
            mul_b = $signed({9'b0, drop_fac});
         end
         OP_PIT_HI: begin
            mul_a  = {{7{pitch_ff[37]}}, pitch_ff[37:19]};
            mul_b  = $signed({9'b0, drop_fac});
            mul_sh = 5'd19;
            mul_hi = 1'b1;
         end
         OP_AMP_A: begin
            mul_a = {{8{res_ff[17]}}, res_ff};
            mul_b = $signed({18'b0, tone_w[23:16]});
         end
         OP_AMP_B: begin
            mul_a = acc_ff[25:0];
            mul_b = {{2{level_ff[23]}}, level_ff};
         end
         OP_LOW_LO: begin
            mul_a = $signed({2'b0, band_ff[23:0]});
            mul_b = $signed({10'b0, f2_ff});
         end
         OP_LOW_HI: begin
            mul_a  = {{2{band_ff[47]}}, band_ff[47:24]};
            mul_b  = $signed({10'b0, f2_ff});
            mul_sh = 5'd24;
            mul_hi = 1'b1;
         end
         OP_RES_LO: begin
            mul_a = $signed({1'b0, diff_ff[24:0]});
            mul_b = $signed({18'b0, tone_w[39:32]});
         end
         OP_RES_HI: begin
            mul_a  = {{2{diff_ff[48]}}, diff_ff[48:25]};
            mul_b  = $signed({18'b0, tone_w[39:32]});
            mul_sh = 5'd25;
            mul_hi = 1'b1;
         end
         OP_BND_LO: begin
            mul_a = $signed({2'b0, high_ff[23:0]});
            mul_b = $signed({10'b0, f2_ff});
         end
         OP_BND_HI: begin
            mul_a  = {{2{high_ff[47]}}, high_ff[47:24]};
            mul_b  = $signed({10'b0, f2_ff});
            mul_sh = 5'd24;
            mul_hi = 1'b1;
         end
         OP_FX_LO: begin
            mul_a = $signed({8'b0, cy_ff[17:0]});
            mul_b = $signed(ROT_K);
         end
         OP_FX_HI: begin
            mul_a  = {{8{cy_ff[35]}}, cy_ff[35:18]};
            mul_b  = $signed(ROT_K);
            mul_sh = 5'd18;
            mul_hi = 1'b1;
         end
         OP_FY_LO: begin
            mul_a = $signed({8'b0, cx_ff[17:0]});
            mul_b = $signed(ROT_K);
         end
         OP_FY_HI: begin
            mul_a  = {{8{cx_ff[35]}}, cx_ff[35:18]};
            mul_b  = $signed(ROT_K);
            mul_sh = 5'd18;
            mul_hi = 1'b1;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign prod     = mul_a * mul_b;
   assign prod_ext = {{12{prod[51]}}, prod};

   // filter output select
   always_comb begin
      case (tone_w[31:24])
         FLT_HIGH:  y_w = {high_ff[47], high_ff};
         FLT_BAND:  y_w = {band_ff[47], band_ff};
         FLT_NOTCH: y_w = {high_ff[47], high_ff} + {low_ff[47], low_ff};
         default:   y_w = {low_ff[47], low_ff};
      endcase
      if (y_w[48:31] == {18{y_w[31]}}) y_sat = y_w[31:0];
      else if (y_w[48])                 y_sat = 32'h80000000;
      else                              y_sat = 32'h7FFFFFFF;
   end

   // next state
   always_comb begin
      phase_in    = phase_ff;
      level_in    = level_ff;
      stage_in    = stage_ff;
      pitch_in    = pitch_ff;
      low_in      = low_ff;
      band_in     = band_ff;
      high_in     = high_ff;
      set_in      = set_ff;
      noise_in    = noise_ff;
      res_in      = res_ff;
      x_in        = x_ff;
      diff_in     = diff_ff;
      f2_in       = f2_ff;
      acc_in      = mul_hi ? acc_ff + (prod_ext << mul_sh) : prod_ext;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      fill_idx_in = fill_idx_ff;
      case (cmd.op)
         OP_TRIG: begin
            if (row_ff) begin
               if (code_ff == 8'd0) begin
                  stage_in = STG_RELEASE;
               end else if (code_ff != 8'd1) begin
                  set_in   = code_ff[7];
                  pitch_in = $signed({1'b0, note_w}) - $signed({1'b0, drop_trig});
                  phase_in = '0;
                  level_in = '0;
                  stage_in = STG_ATTACK;
               end
            end
         end
         OP_ATK: begin
            if (stage_ff == STG_ATTACK) begin
               level_in = lvl_add[23:0];
               if (lvl_add >= 25'sd2097152) stage_in = STG_DECAY;
            end
         end
         OP_DEC: begin
            if (stage_ff == STG_DECAY) begin
               level_in = lvl_sub_d[23:0];
               if (lvl_sub_d <= $signed({3'b0, env_w[23:16], 14'b0})) stage_in = STG_SUSTAIN;
            end else if (stage_ff == STG_RELEASE) begin
               level_in = lvl_sub_r[24] ? '0 : lvl_sub_r[23:0];
            end
         end
         OP_OSC: begin
            phase_in = phase_ff + pitch_ff[31:0] + drop_w[31:0];
            f2_in    = {8'b0, tone_w[47:40]} * {8'b0, tone_w[47:40]};
            if (tone_w[7:0] == WAVE_NOISE) noise_in = n3;
         end
         OP_WAVE: begin
            case (tone_w[7:0])
               WAVE_SQUARE: res_in = phase_ff[31] ? 18'sd65535 : -18'sd65536;
               WAVE_SAW:    res_in = {phase_ff[31], phase_ff[31:16], 1'b0};
               WAVE_TRI:    res_in = tri_val[17:0];
               WAVE_NOISE:  res_in = $signed({1'b0, noise_ff[16:0]}) - 18'sh10000;
               default:     res_in = sine_q_ff;
            endcase
         end
         OP_PIT_FIN: pitch_in = acc_sh16[37:0];
         OP_AMP_FIN: x_in = acc_sh28[21:0];
         OP_LOW_LO: begin
            diff_in = {{27{x_ff[21]}}, x_ff} - {band_ff[47], band_ff};
         end
         OP_LOW_FIN: begin
            low_in = sat48($signed(acc_sh14[50:0]) + {{3{low_ff[47]}}, low_ff});
         end
         OP_RES_FIN: begin
            high_in = sat48($signed(acc_sh7[50:0]) - {{3{low_ff[47]}}, low_ff});
         end
         OP_BND_FIN: begin
            band_in = sat48($signed(acc_sh14[50:0]) + {{3{band_ff[47]}}, band_ff});
         end
         OP_FX_FIN: cx_in = cx_ff - acc_sh32[35:0];
         OP_FY_FIN: begin
            cy_in       = cy_ff + acc_sh32[35:0];
            fill_idx_in = fill_idx_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set0_env_ff  <= '0;
         set1_env_ff  <= '0;
         set0_tone_ff <= '0;
         set1_tone_ff <= '0;
         phase_ff     <= '0;
         level_ff     <= '0;
         stage_ff     <= STG_ATTACK;
         pitch_ff     <= '0;
         low_ff       <= '0;
         band_ff      <= '0;
         set_ff       <= 1'b0;
         noise_ff     <= 64'd1;
         cx_ff        <= 36'sh100000000;
         cy_ff        <= '0;
         fill_idx_ff  <= '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_SET0_ENV:  set0_env_ff  <= csr_wdata[31:0];
               REG_SET0_TONE: set0_tone_ff <= csr_wdata;
               REG_SET1_ENV:  set1_env_ff  <= csr_wdata[31:0];
               REG_SET1_TONE: set1_tone_ff <= csr_wdata;
               default:       set0_env_ff  <= set0_env_ff;
            endcase
         end
         phase_ff    <= phase_in;
         level_ff    <= level_in;
         stage_ff    <= stage_in;
         pitch_ff    <= pitch_in;
         low_ff      <= low_in;
         band_ff     <= band_in;
         set_ff      <= set_in;
         noise_ff    <= noise_in;
         cx_ff       <= cx_in;
         cy_ff       <= cy_in;
         fill_idx_ff <= fill_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff  <= in_row_start;
         code_ff <= in_note_code;
      end
      if (cmd.load_out) out_ff <= y_sat;
      high_ff <= high_in;
      res_ff  <= res_in;
      x_ff    <= x_in;
      diff_ff <= diff_in;
      f2_ff   <= f2_in;
      acc_ff  <= acc_in;
   end

   // table entry is cy >> 16, taken before cy advances
   always_ff @(posedge clock) begin
      if (mem_we) sine_mem[sine_addr] <= cy_ff[33:16];
      sine_q_ff <= sine_mem[sine_addr];
   end

   assign status.fill_last = (fill_idx_ff == SINE_AW'(SINE_ENTRIES - 1));
   assign out_sample       = out_ff;

endmodule

// ----- rtl/svas_ctrl.sv -----
// ----------------------------------------------------------------------------
// svas_ctrl
// sequencer: table fill after reset, then one sample per transaction
// ----------------------------------------------------------------------------
module svas_ctrl import svas_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_TRIG, ST_ATK, ST_DEC, ST_OSC, ST_SRD, ST_WAVE,
      ST_PIT_LO, ST_PIT_HI, ST_PIT_FIN,
      ST_AMP_A, ST_AMP_B, ST_AMP_FIN,
      ST_LOW_LO, ST_LOW_HI, ST_LOW_FIN,
      ST_RES_LO, ST_RES_HI, ST_RES_FIN,
      ST_BND_LO, ST_BND_HI, ST_BND_FIN,
      ST_OUT,
      ST_FX_LO, ST_FX_HI, ST_FX_FIN,
      ST_FY_LO, ST_FY_HI, ST_FY_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      accept;
   logic      load;

   assign accept = req_tvalid && (state_ff == ST_IDLE);
   assign load   = (state_ff == ST_OUT) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_IDLE;
      case (state_ff)
         ST_IDLE:    if (accept) state_in = ST_TRIG;
         ST_TRIG:    begin cmd.op = OP_TRIG;    state_in = ST_ATK;     end
         ST_ATK:     begin cmd.op = OP_ATK;     state_in = ST_DEC;     end
         ST_DEC:     begin cmd.op = OP_DEC;     state_in = ST_OSC;     end
         ST_OSC:     begin cmd.op = OP_OSC;     state_in = ST_SRD;     end
         ST_SRD:     begin cmd.op = OP_SRD;     state_in = ST_WAVE;    end
         ST_WAVE:    begin cmd.op = OP_WAVE;    state_in = ST_PIT_LO;  end
         ST_PIT_LO:  begin cmd.op = OP_PIT_LO;  state_in = ST_PIT_HI;  end
         ST_PIT_HI:  begin cmd.op = OP_PIT_HI;  state_in = ST_PIT_FIN; end
         ST_PIT_FIN: begin cmd.op = OP_PIT_FIN; state_in = ST_AMP_A;   end
         ST_AMP_A:   begin cmd.op = OP_AMP_A;   state_in = ST_AMP_B;   end
         ST_AMP_B:   begin cmd.op = OP_AMP_B;   state_in = ST_AMP_FIN; end
         ST_AMP_FIN: begin cmd.op = OP_AMP_FIN; state_in = ST_LOW_LO;  end
         ST_LOW_LO:  begin cmd.op = OP_LOW_LO;  state_in = ST_LOW_HI;  end
         ST_LOW_HI:  begin cmd.op = OP_LOW_HI;  state_in = ST_LOW_FIN; end
         ST_LOW_FIN: begin cmd.op = OP_LOW_FIN; state_in = ST_RES_LO;  end
         ST_RES_LO:  begin cmd.op = OP_RES_LO;  state_in = ST_RES_HI;  end
         ST_RES_HI:  begin cmd.op = OP_RES_HI;  state_in = ST_RES_FIN; end
         ST_RES_FIN: begin cmd.op = OP_RES_FIN; state_in = ST_BND_LO;  end
         ST_BND_LO:  begin cmd.op = OP_BND_LO;  state_in = ST_BND_HI;  end
         ST_BND_HI:  begin cmd.op = OP_BND_HI;  state_in = ST_BND_FIN; end
         ST_BND_FIN: begin cmd.op = OP_BND_FIN; state_in = ST_OUT;     end
         ST_OUT:     if (load) state_in = ST_IDLE;
         ST_FX_LO:   begin cmd.op = OP_FX_LO;   state_in = ST_FX_HI;   end
         ST_FX_HI:   begin cmd.op = OP_FX_HI;   state_in = ST_FX_FIN;  end
         ST_FX_FIN:  begin cmd.op = OP_FX_FIN;  state_in = ST_FY_LO;   end
         ST_FY_LO:   begin cmd.op = OP_FY_LO;   state_in = ST_FY_HI;   end
         ST_FY_HI:   begin cmd.op = OP_FY_HI;   state_in = ST_FY_FIN;  end
         ST_FY_FIN: begin
            cmd.op   = OP_FY_FIN;
            state_in = status.fill_last ? ST_IDLE : ST_FX_LO;
         end
         default:    state_in = ST_IDLE;
      endcase
      cmd.capture  = accept;
      cmd.load_out = load;
   end

   assign rsp_tvalid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FX_LO;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_TRIG)
      else $error("accepted transaction did not start the trigger step");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_tvalid_ff)
      else $error("result load did not raise rsp_tvalid");

   a_valid_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("rsp_tvalid rose outside the output step");
`endif

endmodule
